// File: src/pkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkst_pkg
// Shared types and constants for the position keyed slot table.
// ----------------------------------------------------------------------------
package pkst_pkg;

	// Table geometry
	localparam int SLOT_COUNT = 1024;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W      = 32;
	localparam int COORD_W    = 16;
	localparam int RADIUS_W   = 7;

	// Keep window radius limits
	localparam logic [RADIUS_W-1:0] RADIUS_MIN   = 7'd1;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 7'd64;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd8;

	// Operation codes
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_UNLOAD = 2'd2;
	localparam logic [1:0] OP_EVICT  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PRESENT   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Configuration register index
	localparam logic REG_WINDOW_RADIUS = 1'b0;

	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status_code;
		logic [9:0]  slot_index;
		logic [10:0] evicted_count;
		logic [10:0] valid_count;
	} rsp_word_t;

endpackage

// File: src/position_keyed_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_keyed_slot_table
// Fully associative table of slots keyed by signed 2D grid positions.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot memory once to clear every valid
// mark, one slot per cycle; requests are stalled during that pass while
// configuration writes are taken as usual. Every operation (lookup, load,
// unload, evict) then walks all slots through a single registered read port
// of the slot memory, one slot per cycle, and finishes with an update step
// that waits while a previous response is still held; the next request is
// taken the cycle after that step. The result sits in an output register,
// so a new request is accepted while the previous response still waits to
// be taken.
module position_keyed_slot_table (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  pkst_pkg::req_word_t  req_data,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output pkst_pkg::rsp_word_t  rsp_data,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import pkst_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              op_q;
	logic [KEY_W-1:0]        key_q;
	logic [RADIUS_W-1:0]     radius_q;
	logic [CNT_W-1:0]        vt_q;
	logic [CNT_W-1:0]        evict_cnt_q;
	logic                    hit_q;
	logic [SLOT_W-1:0]       hit_idx_q;
	logic                    free_q;
	logic [SLOT_W-1:0]       free_idx_q;
	logic                    rd_vld_s1;
	logic [SLOT_W-1:0]       idx_s1;
	logic [KEY_W:0]          rdata_s1;
	logic                    rsp_valid_q;
	rsp_word_t               rsp_q;

	// slot memory: valid mark on top, key below (y high, x low)
	logic [KEY_W:0]          mem [SLOT_COUNT];

	logic                    accept;
	logic                    rd_en;
	logic                    mem_we;
	logic [SLOT_W-1:0]       mem_wa;
	logic [KEY_W:0]          mem_wd;
	logic                    cfg_we;
	logic [RADIUS_W-1:0]     radius_in;
	logic                    slot_valid_s1;
	logic                    match_s1;
	logic                    outside_s1;
	logic signed [16:0]      dx;
	logic signed [16:0]      dy;
	logic signed [16:0]      rad;
	logic                    fin_go;
	logic [CNT_W-1:0]        vt_next;
	rsp_word_t               rsp_next;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign pready    = 1'b1;

	// configuration: clamp the radius into its legal range
	assign cfg_we    = psel && penable && pwrite && (paddr[2] == REG_WINDOW_RADIUS);
	always_comb begin
		radius_in = pwdata[RADIUS_W-1:0];
		if (radius_in < RADIUS_MIN) begin
			radius_in = RADIUS_MIN;
		end else if (radius_in > RADIUS_MAX) begin
			radius_in = RADIUS_MAX;
		end
	end

	assign prdata = (paddr[2] == REG_WINDOW_RADIUS) ? {{(32-RADIUS_W){1'b0}}, radius_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= radius_in;
		end
	end

	// slot memory read and write ports
	assign rd_en = (state_q == S_SCAN) && (cnt_q < CNT_END);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[cnt_q[SLOT_W-1:0]];
		end
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[SLOT_W-1:0];
	end

	// compare the slot read last cycle against the key and the window
	assign slot_valid_s1 = rd_vld_s1 && rdata_s1[KEY_W];
	assign match_s1      = slot_valid_s1 && (rdata_s1[KEY_W-1:0] == key_q);
	assign dx  = $signed({rdata_s1[15], rdata_s1[15:0]}) - $signed({key_q[15], key_q[15:0]});
	assign dy  = $signed({rdata_s1[31], rdata_s1[31:16]}) - $signed({key_q[31], key_q[31:16]});
	assign rad = $signed({{(17-RADIUS_W){1'b0}}, radius_q});
	assign outside_s1 = (dx > rad) || (dx < -rad) || (dy > rad) || (dy < -rad);

	assign fin_go = !rsp_valid_q || !rsp_stall;

	// pick the memory write and build the result
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		vt_next  = vt_q;
		rsp_next = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q[SLOT_W-1:0];
			end
			S_SCAN: begin
				if (op_q == OP_EVICT && slot_valid_s1 && outside_s1) begin
					mem_we = 1'b1;
					mem_wa = idx_s1;
					mem_wd = {1'b0, rdata_s1[KEY_W-1:0]};
				end
			end
			S_FINISH: begin
				unique case (op_q)
					OP_LOOKUP: begin
						rsp_next.status_code = hit_q ? ST_OK : ST_NOT_FOUND;
						rsp_next.slot_index  = hit_q ? 10'(hit_idx_q) : '0;
					end
					OP_LOAD: begin
						if (hit_q) begin
							rsp_next.status_code = ST_PRESENT;
							rsp_next.slot_index  = 10'(hit_idx_q);
						end else if (free_q) begin
							mem_we  = fin_go;
							mem_wa  = free_idx_q;
							mem_wd  = {1'b1, key_q};
							vt_next = vt_q + 1'b1;
							rsp_next.status_code = ST_OK;
							rsp_next.slot_index  = 10'(free_idx_q);
						end else begin
							mem_we = fin_go;
							mem_wa = '0;
							mem_wd = {1'b1, key_q};
							rsp_next.status_code = ST_FULL;
						end
					end
					OP_UNLOAD: begin
						if (hit_q) begin
							mem_we  = fin_go;
							mem_wa  = hit_idx_q;
							mem_wd  = {1'b0, key_q};
							vt_next = vt_q - 1'b1;
							rsp_next.status_code = ST_OK;
							rsp_next.slot_index  = 10'(hit_idx_q);
						end else begin
							rsp_next.status_code = ST_NOT_FOUND;
						end
					end
					OP_EVICT: begin
						rsp_next.status_code   = ST_OK;
						rsp_next.evicted_count = 11'(evict_cnt_q);
					end
					default: begin
						rsp_next.status_code = ST_OK;
					end
				endcase
				rsp_next.valid_count = 11'(vt_next);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer: clear pass, idle, slot sweep, final update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			vt_q        <= '0;
			evict_cnt_q <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// raise the response flag on a finished item, drop it once taken
			if (state_q == S_FINISH && fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_SCAN;
						cnt_q       <= '0;
						evict_cnt_q <= '0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
					end
				end
				S_SCAN: begin
					if (cnt_q < CNT_END) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_FINISH;
					end
					if (match_s1 && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (rd_vld_s1 && !rdata_s1[KEY_W] && !free_q) begin
						free_q <= 1'b1;
					end
					if (op_q == OP_EVICT && slot_valid_s1 && outside_s1) begin
						evict_cnt_q <= evict_cnt_q + 1'b1;
						vt_q        <= vt_q - 1'b1;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						vt_q        <= vt_next;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request and the first hit and free slot found
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_data.opcode;
			key_q <= {req_data.pos_y, req_data.pos_x};
		end
		if (state_q == S_SCAN && match_s1 && !hit_q) begin
			hit_idx_q <= idx_s1;
		end
		if (state_q == S_SCAN && rd_vld_s1 && !rdata_s1[KEY_W] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == S_FINISH && fin_go) begin
			rsp_q <= rsp_next;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vt_q <= CNT_END)
		else $error("valid count above table size");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN) && (cnt_q == '0))
		else $error("accepted request did not start a sweep");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("slot memory written while idle");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("slot read returned outside a sweep");

endmodule
